FILE: design/tlpw_pkg.sv
// Shared types, constants and helpers for the two-level page walk unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package tlpw_pkg;

	// Table geometry and allocator limits
	localparam int FRAME_COUNT   = 256;
	localparam int TOP_ENTRIES   = 8;
	localparam int LEAF_ENTRIES  = 8;
	localparam int PROCESS_SLOTS = 16;

	// Field and storage widths
	localparam int FRAME_W     = 8;
	localparam int IDX_W       = 3;
	localparam int ADDR_W      = FRAME_W + IDX_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;
	localparam int ENTRY_W     = 17;
	localparam int REFS_W      = 8;
	localparam int CNT_W       = 16;
	localparam int SLOT_W      = 4;
	localparam int VPN_W       = 6;
	localparam int NPROC_W     = 5;
	localparam int TAKEN_W     = 9;
	localparam int NEXT_W      = 10;
	localparam int IN_W        = 16;
	localparam int OUT_W       = 64;

	// Result status codes
	typedef enum logic [1:0] {
		RES_OK        = 2'd0,
		RES_NO_FRAMES = 2'd1,
		RES_INACTIVE  = 2'd2
	} res_status_t;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_TOP,
		ST_CHK_TOP,
		ST_CHK_LEAF,
		ST_EVAL,
		ST_WR_TOP,
		ST_ZERO,
		ST_WR_LEAF,
		ST_DONE
	} fsm_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr_step;
		logic capture;
		logic rd_top;
		logic cap_top;
		logic cap_leaf;
		logic eval;
		logic wr_top;
		logic zero_step;
		logic wr_leaf;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clr_last;
		logic inactive;
		logic top_valid;
		logic no_frames;
		logic table_miss;
		logic zero_last;
		logic out_free;
	} dp_sts_t;

	// Saturating counter add
	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {{(CNT_W-1){1'b0}}, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: design/tlpw_ram.sv
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module tlpw_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write or read one word per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

FILE: design/tlpw_ctrl.sv
// Walk controller: sequences clearing, table reads, allocation and write-back.
// Depends on tlpw_pkg for state, command and status types.
`default_nettype none

module tlpw_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire tlpw_pkg::dp_sts_t sts,
	output tlpw_pkg::dp_cmd_t      cmd
);

	tlpw_pkg::fsm_state_t state_q, state_nxt;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlpw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tlpw_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_nxt = tlpw_pkg::ST_IDLE;
			end
			tlpw_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_nxt = sts.inactive ? tlpw_pkg::ST_DONE : tlpw_pkg::ST_RD_TOP;
				end
			end
			tlpw_pkg::ST_RD_TOP: state_nxt = tlpw_pkg::ST_CHK_TOP;
			tlpw_pkg::ST_CHK_TOP: begin
				state_nxt = sts.top_valid ? tlpw_pkg::ST_CHK_LEAF : tlpw_pkg::ST_EVAL;
			end
			tlpw_pkg::ST_CHK_LEAF: state_nxt = tlpw_pkg::ST_EVAL;
			tlpw_pkg::ST_EVAL: begin
				if (sts.no_frames) begin
					state_nxt = tlpw_pkg::ST_DONE;
				end else if (sts.table_miss) begin
					state_nxt = tlpw_pkg::ST_WR_TOP;
				end else begin
					state_nxt = tlpw_pkg::ST_WR_LEAF;
				end
			end
			tlpw_pkg::ST_WR_TOP: state_nxt = tlpw_pkg::ST_ZERO;
			tlpw_pkg::ST_ZERO: begin
				if (sts.zero_last) state_nxt = tlpw_pkg::ST_DONE;
			end
			tlpw_pkg::ST_WR_LEAF: state_nxt = tlpw_pkg::ST_DONE;
			tlpw_pkg::ST_DONE: begin
				if (sts.out_free) state_nxt = tlpw_pkg::ST_IDLE;
			end
			default: state_nxt = tlpw_pkg::ST_IDLE;
		endcase
	end

	// Decode commands
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			tlpw_pkg::ST_CLEAR:    cmd.clr_step = 1'b1;
			tlpw_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			tlpw_pkg::ST_RD_TOP:   cmd.rd_top    = 1'b1;
			tlpw_pkg::ST_CHK_TOP:  cmd.cap_top   = 1'b1;
			tlpw_pkg::ST_CHK_LEAF: cmd.cap_leaf  = 1'b1;
			tlpw_pkg::ST_EVAL:     cmd.eval      = 1'b1;
			tlpw_pkg::ST_WR_TOP:   cmd.wr_top    = 1'b1;
			tlpw_pkg::ST_ZERO:     cmd.zero_step = 1'b1;
			tlpw_pkg::ST_WR_LEAF:  cmd.wr_leaf   = 1'b1;
			tlpw_pkg::ST_DONE:     cmd.load_out  = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: design/tlpw_dp.sv
// Walk datapath: entry store, allocator, per-process counters, result register.
// Depends on tlpw_pkg and tlpw_ram.
`default_nettype none

module tlpw_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tlpw_pkg::dp_cmd_t             cmd,
	output tlpw_pkg::dp_sts_t                  sts,
	input  wire logic [tlpw_pkg::IN_W-1:0]     in_data,
	input  wire logic                          cfg_we,
	input  wire logic [tlpw_pkg::NPROC_W-1:0]  cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [tlpw_pkg::OUT_W-1:0]    out_data
);

	localparam int AW = tlpw_pkg::ADDR_W;
	localparam int FW = tlpw_pkg::FRAME_W;
	localparam int IW = tlpw_pkg::IDX_W;
	localparam int EW = tlpw_pkg::ENTRY_W;
	localparam int CW = tlpw_pkg::CNT_W;
	localparam int RW = tlpw_pkg::REFS_W;
	localparam int SW = tlpw_pkg::SLOT_W;
	localparam int NW = tlpw_pkg::NEXT_W;

	// Configuration and allocator state
	logic [tlpw_pkg::NPROC_W-1:0] nproc_q;
	logic [tlpw_pkg::TAKEN_W-1:0] taken_q;
	logic [AW-1:0]                clr_cnt_q;
	logic [IW-1:0]                zcnt_q;
	logic [CW-1:0]                fault_cnt_q [tlpw_pkg::PROCESS_SLOTS];
	logic [CW-1:0]                ref_cnt_q   [tlpw_pkg::PROCESS_SLOTS];

	// Captured reference and walk state
	logic [SW-1:0]               slot_q;
	logic [tlpw_pkg::VPN_W-1:0]  vpn_q;
	logic                        top_valid_q;
	logic [FW-1:0]               top_frame_q;
	logic [EW-1:0]               leaf_q;

	// Result registers
	tlpw_pkg::res_status_t res_status_q;
	logic [FW-1:0]         res_tframe_q;
	logic                  res_tfault_q;
	logic [FW-1:0]         res_pframe_q;
	logic                  res_pfault_q;
	logic [RW-1:0]         res_refs_q;
	logic [CW-1:0]         res_pf_q;
	logic [CW-1:0]         res_pr_q;

	logic                  out_valid_q;
	logic [tlpw_pkg::OUT_W-1:0] out_data_q;

	// Memory port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [EW-1:0] ram_wdata;
	logic [EW-1:0] ram_rdata;

	// Derived values
	logic [tlpw_pkg::NPROC_W-1:0] active;
	logic [SW-1:0]                in_slot;
	logic [IW-1:0]                top_idx;
	logic [IW-1:0]                leaf_idx;
	logic [AW-1:0]                top_addr;
	logic                         t_fault;
	logic                         p_fault;
	logic [1:0]                   need;
	logic [NW-1:0]                next_frame;
	logic [NW-1:0]                next_end;
	logic                         no_frames;
	logic [FW-1:0]                tframe;
	logic [FW-1:0]                pframe;
	logic [RW-1:0]                refs;
	logic [CW-1:0]                faults_new;
	logic [CW-1:0]                refs_new;
	logic [EW-1:0]                leaf_word;

	// Index and address arithmetic
	always_comb begin
		active = (nproc_q < tlpw_pkg::NPROC_W'(tlpw_pkg::PROCESS_SLOTS))
			? nproc_q : tlpw_pkg::NPROC_W'(tlpw_pkg::PROCESS_SLOTS);
		in_slot    = in_data[SW-1:0];
		top_idx    = IW'({1'b0, vpn_q[5:3]} % 4'(tlpw_pkg::TOP_ENTRIES));
		leaf_idx   = IW'({1'b0, vpn_q[2:0]} % 4'(tlpw_pkg::LEAF_ENTRIES));
		top_addr   = {FW'(slot_q), top_idx};
		t_fault    = !top_valid_q;
		p_fault    = !leaf_q[EW-1];
		need       = t_fault ? 2'd2 : {1'b0, p_fault};
		next_frame = NW'(active) + NW'(taken_q);
		next_end   = next_frame + NW'(need);
		no_frames  = next_end > NW'(tlpw_pkg::FRAME_COUNT);
		tframe     = t_fault ? next_frame[FW-1:0] : top_frame_q;
		pframe     = !p_fault ? leaf_q[FW-1:0]
			: (t_fault ? next_frame[FW-1:0] + FW'(1) : next_frame[FW-1:0]);
		refs       = p_fault ? RW'(1) : leaf_q[FW+RW-1:FW] + RW'(1);
		faults_new = tlpw_pkg::sat_add(fault_cnt_q[slot_q],
			2'(t_fault) + 2'(p_fault));
		refs_new   = tlpw_pkg::sat_add(ref_cnt_q[slot_q], 2'd1);
		leaf_word  = {1'b1, res_refs_q, res_pframe_q};
	end

	// Steer the single memory port
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = top_addr;
		ram_wdata = '0;
		if (cmd.clr_step) begin
			ram_we   = 1'b1;
			ram_addr = clr_cnt_q;
		end else if (cmd.rd_top) begin
			ram_addr = top_addr;
		end else if (cmd.cap_top) begin
			ram_addr = {ram_rdata[FW-1:0], leaf_idx};
		end else if (cmd.wr_top) begin
			ram_we    = 1'b1;
			ram_wdata = {1'b1, {RW{1'b0}}, res_tframe_q};
		end else if (cmd.zero_step) begin
			ram_we    = 1'b1;
			ram_addr  = {res_tframe_q, zcnt_q};
			ram_wdata = (zcnt_q == leaf_idx) ? leaf_word : '0;
		end else if (cmd.wr_leaf) begin
			ram_we    = 1'b1;
			ram_addr  = {res_tframe_q, leaf_idx};
			ram_wdata = leaf_word;
		end
	end

	tlpw_ram #(
		.WIDTH(EW),
		.DEPTH(tlpw_pkg::STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Hold configuration, allocator and sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nproc_q   <= tlpw_pkg::NPROC_W'(1);
			taken_q   <= '0;
			clr_cnt_q <= '0;
			zcnt_q    <= '0;
		end else begin
			if (cfg_we) nproc_q <= cfg_data;
			if (cmd.clr_step) clr_cnt_q <= clr_cnt_q + AW'(1);
			if (cmd.wr_top) begin
				zcnt_q <= '0;
			end else if (cmd.zero_step) begin
				zcnt_q <= zcnt_q + IW'(1);
			end
			if (cmd.eval && !no_frames) taken_q <= taken_q + tlpw_pkg::TAKEN_W'(need);
		end
	end

	// Update per-process counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tlpw_pkg::PROCESS_SLOTS; i++) begin
				fault_cnt_q[i] <= '0;
				ref_cnt_q[i]   <= '0;
			end
		end else if (cmd.eval && !no_frames) begin
			fault_cnt_q[slot_q] <= faults_new;
			ref_cnt_q[slot_q]   <= refs_new;
		end
	end

	// Capture the reference, walk entries and results
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q       <= in_slot;
			vpn_q        <= in_data[SW+tlpw_pkg::VPN_W-1:SW];
			res_status_q <= tlpw_pkg::RES_INACTIVE;
			res_tframe_q <= '0;
			res_tfault_q <= 1'b0;
			res_pframe_q <= '0;
			res_pfault_q <= 1'b0;
			res_refs_q   <= '0;
			res_pf_q     <= '0;
			res_pr_q     <= '0;
		end
		if (cmd.cap_top) begin
			top_valid_q <= ram_rdata[EW-1];
			top_frame_q <= ram_rdata[FW-1:0];
			leaf_q      <= '0;
		end
		if (cmd.cap_leaf) leaf_q <= ram_rdata;
		if (cmd.eval) begin
			if (no_frames) begin
				res_status_q <= tlpw_pkg::RES_NO_FRAMES;
			end else begin
				res_status_q <= tlpw_pkg::RES_OK;
				res_tframe_q <= tframe;
				res_tfault_q <= t_fault;
				res_pframe_q <= pframe;
				res_pfault_q <= p_fault;
				res_refs_q   <= refs;
				res_pf_q     <= faults_new;
				res_pr_q     <= refs_new;
			end
		end
		if (cmd.load_out) begin
			out_data_q <= {4'b0, res_pr_q, res_pf_q, res_refs_q, res_pfault_q,
				res_pframe_q, res_tfault_q, res_tframe_q, 2'(res_status_q)};
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Report status to the controller
	always_comb begin
		sts.clr_last   = &clr_cnt_q;
		sts.inactive   = !(NW'(in_slot) < NW'(active));
		sts.top_valid  = ram_rdata[EW-1];
		sts.no_frames  = no_frames;
		sts.table_miss = t_fault;
		sts.zero_last  = &zcnt_q;
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

FILE: design/two_level_page_walk_demand_alloc_unit.sv
// Top level of the two-level page walk unit with demand frame allocation.
// Depends on tlpw_pkg, tlpw_ctrl and tlpw_dp (which holds tlpw_ram).
//
//   Channel   Direction  Handshake                Payload
//   s_axis    in         s_axis_tvalid/tready     one page reference
//   m_axis    out        m_axis_tvalid/tready     one walk result
//   cfg       in         cfg_valid/cfg_ready      num_processes
//
// A reference steps through the top-entry read and check, the leaf check (only when
// the top entry is valid), evaluation, then a leaf write on a hit or page-only fault,
// or a top write and eight-entry clear of a new level-2 table; out of frames it skips
// the writes, and an inactive slot goes straight to the result. After reset all 2048
// store entries are swept to zero, during which no reference is accepted.
// A finished result waits in the output register while the next reference is accepted.
`default_nettype none

module two_level_page_walk_demand_alloc_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [3:0] process_slot, [9:4] virtual_page, [15:10] zero
	input  wire logic [tlpw_pkg::IN_W-1:0]           s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [1:0] status, [9:2] table_frame, [10] table_fault, [18:11] page_frame,
	// [19] page_fault, [27:20] page_refs, [43:28] process_faults,
	// [59:44] process_refs, [63:60] zero
	output logic      [tlpw_pkg::OUT_W-1:0]          m_axis_tdata,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [tlpw_pkg::NPROC_W-1:0]        cfg_data
);

	tlpw_pkg::dp_cmd_t cmd;
	tlpw_pkg::dp_sts_t sts;

	// Take configuration words at any time
	assign cfg_ready = 1'b1;

	tlpw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	tlpw_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_axis_tdata),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata)
	);

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking bench for two_level_page_walk_demand_alloc_unit: streams page references,
// predicts each walk result in a local model of the page tables and compares every word.
// Depends on tlpw_pkg and the top level of the page walk unit.
`default_nettype none

module testbench;
	import tlpw_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 6000;
	localparam int SETTLE      = 16;
	localparam int GAP_PCT     = 27;
	localparam logic [3:0] HOT_SLOT = 4'd1;
	localparam logic [5:0] HOT_PAGE = 6'h3B;

	// One page reference on the input stream
	typedef struct packed {
		logic [VPN_W-1:0]  vpn;
		logic [SLOT_W-1:0] slot;
	} page_ref_t;

	// One walk result, packed so that status sits in the lowest bits as on m_axis_tdata
	typedef struct packed {
		logic [CNT_W-1:0]   proc_refs;
		logic [CNT_W-1:0]   proc_faults;
		logic [REFS_W-1:0]  page_refs;
		logic               page_fault;
		logic [FRAME_W-1:0] page_frame;
		logic               tbl_fault;
		logic [FRAME_W-1:0] tbl_frame;
		res_status_t        status;
	} walk_res_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	// [3:0] process_slot, [9:4] virtual_page, [15:10] zero
	logic [IN_W-1:0]     s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	// [1:0] status, [9:2] table_frame, [10] table_fault, [18:11] page_frame,
	// [19] page_fault, [27:20] page_refs, [43:28] process_faults, [59:44] process_refs
	logic [OUT_W-1:0]    m_axis_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [NPROC_W-1:0]  cfg_data = '0;

	// Predictor state: page tables, allocator, per-process counters, register copy
	logic [ENTRY_W-1:0]  frame_store [STORE_DEPTH];
	logic [TAKEN_W-1:0]  frames_out;
	logic [CNT_W-1:0]    fault_cnt [PROCESS_SLOTS];
	logic [CNT_W-1:0]    ref_cnt [PROCESS_SLOTS];
	logic [NPROC_W-1:0]  active_procs;

	page_ref_t           refs_to_send [$];
	walk_res_t           pending_walks [$];

	logic                s_taken = 1'b0;
	logic                no_gap = 1'b0;
	logic                stall_req = 1'b0;
	logic                stall_seen = 1'b0;
	int                  stall_left = 0;
	int                  quiet_cycles = 0;
	int                  bad_count = 0;
	int                  walks_sent = 0;
	int                  n_ok = 0;
	int                  n_no_frames = 0;
	int                  n_inactive = 0;
	int                  n_tbl_faults = 0;
	int                  n_page_faults = 0;

	two_level_page_walk_demand_alloc_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < STORE_DEPTH; i++) frame_store[i] = '0;
		for (int i = 0; i < PROCESS_SLOTS; i++) begin
			fault_cnt[i] = '0;
			ref_cnt[i] = '0;
		end
		frames_out = '0;
		active_procs = NPROC_W'(1);
	end

	function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] a, input int b);
		int s;
		s = int'(a) + b;
		return (s > 65535) ? 16'hFFFF : CNT_W'(s);
	endfunction

	// Walk the local page tables for one reference, allocating on demand
	function automatic walk_res_t predict_walk(input logic [SLOT_W-1:0] slot,
			input logic [VPN_W-1:0] vpn);
		walk_res_t          r;
		int                 active, need, nxt;
		logic [IDX_W-1:0]   top_idx, leaf_idx;
		logic [ADDR_W-1:0]  top_a, leaf_a;
		logic [ENTRY_W-1:0] top_e, leaf_e;
		logic               tf, pf;
		logic [FRAME_W-1:0] tfr, pfr;
		logic [REFS_W-1:0]  refs;
		r = '0;
		active = (int'(active_procs) < PROCESS_SLOTS) ? int'(active_procs) : PROCESS_SLOTS;
		if (int'(slot) >= active) begin
			r.status = RES_INACTIVE;
			return r;
		end
		top_idx = IDX_W'(int'(vpn[5:3]) % TOP_ENTRIES);
		leaf_idx = IDX_W'(int'(vpn[2:0]) % LEAF_ENTRIES);
		top_a = {4'd0, slot, top_idx};
		top_e = frame_store[top_a];
		tf = !top_e[16];
		if (tf) begin
			need = 2;
			leaf_e = '0;
		end else begin
			leaf_e = frame_store[{top_e[7:0], leaf_idx}];
			need = leaf_e[16] ? 0 : 1;
		end
		pf = !leaf_e[16];
		nxt = active + int'(frames_out);
		if (nxt + need > FRAME_COUNT) begin
			r.status = RES_NO_FRAMES;
			return r;
		end
		// New level-2 table: hook it in, then clear its frame
		if (tf) begin
			tfr = FRAME_W'(nxt);
			nxt++;
			frame_store[top_a] = {1'b1, 8'd0, tfr};
			for (int k = 0; k < 8; k++) frame_store[{tfr, IDX_W'(k)}] = '0;
		end else begin
			tfr = top_e[7:0];
		end
		leaf_a = {tfr, leaf_idx};
		leaf_e = frame_store[leaf_a];
		if (pf) begin
			pfr = FRAME_W'(nxt);
			leaf_e = {1'b1, 8'd0, pfr};
		end else begin
			pfr = leaf_e[7:0];
		end
		refs = leaf_e[15:8] + 8'd1;
		frame_store[leaf_a] = {1'b1, refs, pfr};
		frames_out = frames_out + TAKEN_W'(need);
		fault_cnt[slot] = count_up(fault_cnt[slot], int'(tf) + int'(pf));
		ref_cnt[slot] = count_up(ref_cnt[slot], 1);
		r.status = RES_OK;
		r.tbl_frame = tfr;
		r.tbl_fault = tf;
		r.page_frame = pfr;
		r.page_fault = pf;
		r.page_refs = refs;
		r.proc_faults = fault_cnt[slot];
		r.proc_refs = ref_cnt[slot];
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		bad_count++;
		if (bad_count <= 10)
			$display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Present references from the queue; hold a word until it is taken
	always @(negedge clk) begin : ref_driver
		page_ref_t pr;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_taken) begin
			if (refs_to_send.size() > 0 && (no_gap || $urandom_range(99) >= GAP_PCT)) begin
				pr = refs_to_send.pop_front();
				s_axis_tdata <= {{(IN_W - SLOT_W - VPN_W){1'b0}}, pr.vpn, pr.slot};
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result sink: random back-pressure plus one long hold-off on request
	always @(negedge clk) begin : result_sink
		if (stall_req && !stall_seen) begin
			stall_seen = 1'b1;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= no_gap || ($urandom_range(99) >= GAP_PCT);
		end
	end

	// Check finished walks, then predict newly accepted references
	always @(posedge clk) begin : walk_checker
		walk_res_t got, want;
		logic      s_fire, m_fire, c_fire;
		s_fire = s_axis_tvalid && s_axis_tready;
		m_fire = m_axis_tvalid && m_axis_tready;
		c_fire = cfg_valid && cfg_ready;
		if (m_fire) begin
			got = walk_res_t'(m_axis_tdata[59:0]);
			if (pending_walks.size() == 0) begin
				note_mismatch("unexpected result word, data low bits", 0, int'(m_axis_tdata[31:0]));
			end else begin
				want = pending_walks.pop_front();
				if (got.status != want.status)
					note_mismatch("status", int'(want.status), int'(got.status));
				if (got.tbl_frame != want.tbl_frame)
					note_mismatch("table_frame", int'(want.tbl_frame), int'(got.tbl_frame));
				if (got.tbl_fault != want.tbl_fault)
					note_mismatch("table_fault", int'(want.tbl_fault), int'(got.tbl_fault));
				if (got.page_frame != want.page_frame)
					note_mismatch("page_frame", int'(want.page_frame), int'(got.page_frame));
				if (got.page_fault != want.page_fault)
					note_mismatch("page_fault", int'(want.page_fault), int'(got.page_fault));
				if (got.page_refs != want.page_refs)
					note_mismatch("page_refs", int'(want.page_refs), int'(got.page_refs));
				if (got.proc_faults != want.proc_faults)
					note_mismatch("process_faults", int'(want.proc_faults), int'(got.proc_faults));
				if (got.proc_refs != want.proc_refs)
					note_mismatch("process_refs", int'(want.proc_refs), int'(got.proc_refs));
				case (want.status)
					RES_OK: begin
						n_ok++;
						n_tbl_faults += int'(want.tbl_fault);
						n_page_faults += int'(want.page_fault);
					end
					RES_NO_FRAMES: n_no_frames++;
					default: n_inactive++;
				endcase
			end
		end
		if (s_fire) begin
			pending_walks.push_back(predict_walk(s_axis_tdata[3:0], s_axis_tdata[9:4]));
			walks_sent++;
		end
		if (c_fire)
			active_procs = cfg_data;
		s_taken <= s_fire;
		quiet_cycles <= (s_fire || m_fire || c_fire) ? 0 : quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
			QUIET_LIMIT, pending_walks.size());
		$display("Some tests failed");
		$finish;
	end

	task automatic add_ref(input int slot, input int vpn);
		page_ref_t pr;
		pr.slot = SLOT_W'(slot);
		pr.vpn = VPN_W'(vpn);
		refs_to_send.push_back(pr);
	endtask

	// Wait until every reference is sent and every result is back; sample at the
	// rising edge, where the queue and the valid line always agree
	task automatic drain();
		while (refs_to_send.size() != 0 || s_axis_tvalid || pending_walks.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_procs(input int value);
		drain();
		repeat (SETTLE) @(negedge clk);
		cfg_data <= NPROC_W'(value);
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Mostly active slots with page locality; some stray slots and a hot page
	task automatic queue_walks(input int count, input int active, input int hot_pct);
		int slot, vpn;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < hot_pct) begin
				add_ref(HOT_SLOT, HOT_PAGE);
			end else begin
				slot = ($urandom_range(99) < 90) ? $urandom_range(active - 1, 0)
					: $urandom_range(15, 0);
				if ($urandom_range(1, 0) == 1)
					vpn = $urandom_range(63, 0);
				else
					vpn = $urandom_range(7, 0) | ($urandom_range(1, 0) ? 6'h38 : 6'h00);
				add_ref(slot, vpn);
			end
		end
	endtask

	initial begin : stimulus
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// Single active slot after reset: faults, hits, far indexes, inactive slots
		add_ref(0, 6'h00);
		add_ref(0, 6'h01);
		add_ref(0, 6'h00);
		add_ref(0, 6'h3F);
		add_ref(0, 6'h08);
		add_ref(0, 6'h38);
		add_ref(1, 6'h00);
		add_ref(15, 6'h3F);
		write_procs(16);
		add_ref(15, 6'h00);
		add_ref(15, 6'h3F);
		add_ref(7, 6'h2A);
		add_ref(7, 6'h2D);
		add_ref(15, 6'h00);
		add_ref(8, 6'h15);
		// No slot active at all
		write_procs(0);
		add_ref(0, 6'h00);
		add_ref(3, 6'h05);
		// Register above the slot count acts as all slots
		write_procs(31);
		add_ref(15, 6'h01);
		add_ref(0, 6'h00);

		// Hot page at full rate so its reference count wraps
		write_procs(4);
		no_gap = 1'b1;
		queue_walks(300, 4, 95);
		drain();
		no_gap = 1'b0;

		// All slots, with a long result hold-off that backs up the input
		write_procs(16);
		stall_req = 1'b1;
		queue_walks(200, 16, 0);

		// Shrink the slot count after walks: allocator lands on frames in use
		write_procs(2);
		queue_walks(100, 2, 0);

		// Wide register value; runs the allocator out of frames
		write_procs(31);
		queue_walks(250, 16, 0);

		write_procs(1);
		queue_walks(80, 1, 0);

		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d references: %0d walked, %0d out of frames, %0d inactive slot",
			walks_sent, n_ok, n_no_frames, n_inactive);
		$display("Faults seen: %0d table, %0d page; mismatches: %0d",
			n_tbl_faults, n_page_faults, bad_count);
		if (bad_count == 0 && pending_walks.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

FILE: files.f
design/tlpw_pkg.sv
design/tlpw_ram.sv
design/tlpw_ctrl.sv
design/tlpw_dp.sv
design/two_level_page_walk_demand_alloc_unit.sv
tb/testbench.sv
